[rtl/cbr_packet_slot_generator_core_assert.svh]
// assertion macros shared by the slot generator rtl
`ifndef CBR_PACKET_SLOT_GENERATOR_CORE_ASSERT_SVH
`define CBR_PACKET_SLOT_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CBR_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CBR_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cbr_psg_pkg.sv]
// package: constants and shared types of the slot generator
package cbr_psg_pkg;

  // datapath widths
  localparam int DIV_W  = 24;
  localparam int PPS_W  = 20;
  localparam int SLOT_W = 10;
  localparam int RATE_W = 24;

  // schedule constants
  localparam int PERIOD_MS = 1000;
  localparam logic [RATE_W-1:0] RATE_MAX_KBPS = RATE_W'(10000000);
  localparam logic [DIV_W-1:0] KBPS_PER_PPS = DIV_W'(12);
  localparam logic [DIV_W-1:0] PPS_ROUND = DIV_W'(6);

  // request to the shared divider
  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  // answer of the shared divider
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

  // one finished slot result
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] packet_count;
    logic [SLOT_W-1:0] ms_stamp;
    logic              period_last;
  } slot_res_t;

endpackage

[rtl/cbr_psg_div.sv]
// module: shared radix-2 restoring divider, one quotient bit per cycle
module cbr_psg_div (
  input  logic                  clk,
  input  logic                  rst,
  input  cbr_psg_pkg::div_req_t req,
  output cbr_psg_pkg::div_rsp_t rsp
);

  localparam int W   = cbr_psg_pkg::DIV_W;
  localparam int CNT_W = $clog2(W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     quo;
  logic [W-1:0]     rem;
  logic [W-1:0]     dsr;

  logic [W:0]       trial;
  logic [W:0]       trial_sub;
  logic             fits;

  // one shift-subtract step
  assign trial     = {rem, quo[W-1]};
  assign trial_sub = trial - {1'b0, dsr};
  assign fits      = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quo  <= req.dividend;
        dsr  <= req.divisor;
        rem  <= '0;
        cnt  <= CNT_W'(W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? trial_sub[W-1:0] : trial[W-1:0];
        quo <= {quo[W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

[rtl/cbr_psg_ctrl.sv]
// module: sequencer for period set-up and per-slot packet counts
module cbr_psg_ctrl (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  go,
  input  logic                                  restart,
  input  logic [cbr_psg_pkg::RATE_W-1:0]        rate,
  input  logic                                  out_free,
  output logic                                  idle,
  output cbr_psg_pkg::div_req_t                 div_req,
  input  cbr_psg_pkg::div_rsp_t                 div_rsp,
  output cbr_psg_pkg::slot_res_t                res
);

  localparam int DIV_W  = cbr_psg_pkg::DIV_W;
  localparam int PPS_W  = cbr_psg_pkg::PPS_W;
  localparam int SLOT_W = cbr_psg_pkg::SLOT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_PPS, S_GCD, S_PACK, S_SLOTS, S_SHARE,
    S_POS, S_COUNT, S_SPARSE, S_EMIT
  } state_t;

  state_t            state;
  logic              setup_done;
  logic [PPS_W-1:0]  pps;
  logic [SLOT_W-1:0] gy;
  logic [PPS_W-1:0]  period_packets;
  logic [SLOT_W-1:0] period_slots;
  logic              dense;
  logic [SLOT_W-1:0] base_share;
  logic [SLOT_W-1:0] extra_share;
  logic [SLOT_W-1:0] slot_spacing;
  logic [SLOT_W-1:0] slot_position;
  logic [SLOT_W-1:0] pos_cur;
  logic [SLOT_W-1:0] count_r;
  logic [SLOT_W-1:0] stamp_r;
  logic              last_r;

  logic [cbr_psg_pkg::RATE_W-1:0] rate_clamped;
  logic [SLOT_W-1:0]              slots_q;
  logic [SLOT_W-1:0]              pos_inc;

  // clamp the rate and pick up quotient bits
  assign rate_clamped = (rate > cbr_psg_pkg::RATE_MAX_KBPS) ? cbr_psg_pkg::RATE_MAX_KBPS : rate;
  assign slots_q      = div_rsp.quotient[SLOT_W-1:0];
  assign pos_inc      = pos_cur + 1'b1;

  // sequencer with schedule state and registered divider requests
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      setup_done     <= 1'b0;
      pps            <= '0;
      gy             <= SLOT_W'(cbr_psg_pkg::PERIOD_MS);
      period_packets <= '0;
      period_slots   <= SLOT_W'(1);
      dense          <= 1'b0;
      base_share     <= '0;
      extra_share    <= '0;
      slot_spacing   <= SLOT_W'(1);
      slot_position  <= '0;
      pos_cur        <= '0;
      div_req        <= '0;
    end else begin
      div_req.start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (restart) begin
            setup_done    <= 1'b0;
            slot_position <= '0;
          end else if (go) begin
            if (!setup_done) begin
              div_req.start    <= 1'b1;
              div_req.dividend <= DIV_W'(rate_clamped) + cbr_psg_pkg::PPS_ROUND;
              div_req.divisor  <= cbr_psg_pkg::KBPS_PER_PPS;
              state            <= S_PPS;
            end else begin
              state <= S_POS;
            end
          end
        end
        // packets per second, then first euclid step against the period
        S_PPS: begin
          if (div_rsp.done) begin
            pps              <= div_rsp.quotient[PPS_W-1:0];
            gy               <= SLOT_W'(cbr_psg_pkg::PERIOD_MS);
            div_req.start    <= 1'b1;
            div_req.dividend <= div_rsp.quotient;
            div_req.divisor  <= DIV_W'(cbr_psg_pkg::PERIOD_MS);
            state            <= S_GCD;
          end
        end
        // euclid loop: divisor becomes dividend, remainder becomes divisor
        S_GCD: begin
          if (div_rsp.done) begin
            div_req.start <= 1'b1;
            if (div_rsp.remainder == '0) begin
              div_req.dividend <= DIV_W'(pps);
              div_req.divisor  <= DIV_W'(gy);
              state            <= S_PACK;
            end else begin
              div_req.dividend <= DIV_W'(gy);
              div_req.divisor  <= div_rsp.remainder;
              gy               <= div_rsp.remainder[SLOT_W-1:0];
            end
          end
        end
        // packets per period
        S_PACK: begin
          if (div_rsp.done) begin
            period_packets   <= div_rsp.quotient[PPS_W-1:0];
            div_req.start    <= 1'b1;
            div_req.dividend <= DIV_W'(cbr_psg_pkg::PERIOD_MS);
            div_req.divisor  <= DIV_W'(gy);
            state            <= S_SLOTS;
          end
        end
        // slots per period, then share or spacing
        S_SLOTS: begin
          if (div_rsp.done) begin
            period_slots <= slots_q;
            base_share   <= '0;
            extra_share  <= '0;
            slot_spacing <= SLOT_W'(1);
            if (period_packets >= PPS_W'(slots_q)) begin
              dense            <= 1'b1;
              div_req.start    <= 1'b1;
              div_req.dividend <= DIV_W'(period_packets);
              div_req.divisor  <= DIV_W'(slots_q);
              state            <= S_SHARE;
            end else if (period_packets != '0) begin
              dense            <= 1'b0;
              div_req.start    <= 1'b1;
              div_req.dividend <= DIV_W'(slots_q);
              div_req.divisor  <= DIV_W'(period_packets);
              state            <= S_SHARE;
            end else begin
              dense         <= 1'b0;
              setup_done    <= 1'b1;
              slot_position <= '0;
              state         <= S_POS;
            end
          end
        end
        S_SHARE: begin
          if (div_rsp.done) begin
            if (dense) begin
              base_share  <= div_rsp.quotient[SLOT_W-1:0];
              extra_share <= div_rsp.remainder[SLOT_W-1:0];
            end else begin
              slot_spacing <= div_rsp.quotient[SLOT_W-1:0];
            end
            setup_done    <= 1'b1;
            slot_position <= '0;
            state         <= S_POS;
          end
        end
        // current slot, wrapped into the period
        S_POS: begin
          pos_cur <= (slot_position >= period_slots) ? '0 : slot_position;
          state   <= S_COUNT;
        end
        // stamp, end flag and count for the dense and empty cases
        S_COUNT: begin
          stamp_r <= pos_inc;
          last_r  <= (pos_inc == period_slots);
          if (period_packets == '0) begin
            count_r <= '0;
            state   <= S_EMIT;
          end else if (dense) begin
            count_r <= base_share + SLOT_W'(pos_cur < extra_share);
            state   <= S_EMIT;
          end else begin
            div_req.start    <= 1'b1;
            div_req.dividend <= DIV_W'(period_slots - 1'b1 - pos_cur);
            div_req.divisor  <= DIV_W'(slot_spacing);
            state            <= S_SPARSE;
          end
        end
        // sparse slot: on the spacing grid and within the packet count
        S_SPARSE: begin
          if (div_rsp.done) begin
            count_r <= SLOT_W'((div_rsp.remainder == '0) &&
                               (div_rsp.quotient < DIV_W'(period_packets)));
            state   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            slot_position <= last_r ? '0 : pos_inc;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle             = (state == S_IDLE);
  assign res.valid        = (state == S_EMIT) && out_free;
  assign res.packet_count = count_r;
  assign res.ms_stamp     = stamp_r;
  assign res.period_last  = last_r;

endmodule

[rtl/cbr_packet_slot_generator_core.sv]
// Constant-bit-rate slot generator: each tick item yields the packet count, 1-based millisecond
// stamp and end-of-period flag for the current slot. One item at a time: a steady tick needs no
// division in the dense and empty cases and one division by the spacing in the sparse case. The
// first tick after reset or a rate write also runs the period set-up: 4 to about 20 divisions
// (rate to packets/s, Euclid's steps against 1000 ms, the reductions and the share). All division
// runs on one shared 24-bit divider that retires one quotient bit per cycle. Write rate_kbps only
// while idle.
`include "cbr_packet_slot_generator_core_assert.svh"

module cbr_packet_slot_generator_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               tick,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [cbr_psg_pkg::SLOT_W-1:0]     packet_count,
  output logic [cbr_psg_pkg::SLOT_W-1:0]     ms_stamp,
  output logic                               period_last,
  input  logic                               rate_kbps_we,
  input  logic [cbr_psg_pkg::RATE_W-1:0]     rate_kbps
);

  logic [cbr_psg_pkg::RATE_W-1:0] rate_reg;
  logic                           in_take;
  logic                           ctrl_idle;
  logic                           out_free;
  logic                           stamp_ok;
  cbr_psg_pkg::div_req_t          div_req;
  cbr_psg_pkg::div_rsp_t          div_rsp;
  cbr_psg_pkg::slot_res_t         res;

  // input handshake: busy in reset and while an item is at work
  assign in_stall = rst || !ctrl_idle;
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // rate register
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_reg <= '0;
    end else if (rate_kbps_we) begin
      rate_reg <= rate_kbps;
    end
  end

  // output register, loaded whenever the sequencer hands over an item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid    <= 1'b1;
      packet_count <= res.packet_count;
      ms_stamp     <= res.ms_stamp;
      period_last  <= res.period_last;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  cbr_psg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .go       (in_take && tick),
    .restart  (rate_kbps_we),
    .rate     (rate_reg),
    .out_free (out_free),
    .idle     (ctrl_idle),
    .div_req  (div_req),
    .div_rsp  (div_rsp),
    .res      (res)
  );

  cbr_psg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // stamp stays within one period
  assign stamp_ok = (ms_stamp != '0) && (ms_stamp <= 10'd1000);

  // checks
  `CBR_ASSERT_NEXT(a_busy_after_tick, clk, rst, in_take && tick, in_stall, "tick item not in work")
  `CBR_ASSERT_NOW(a_no_overwrite, clk, rst, res.valid, out_free, "output register overwritten")
  `CBR_ASSERT_NOW(a_stamp_range, clk, rst, out_valid, stamp_ok, "stamp out of range")
  `CBR_ASSERT_NOW(a_div_idle_start, clk, rst, div_req.start, !div_rsp.done, "divider restarted on done")

endmodule
